/* design/hopfield_annealing_relaxation_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the annealing relaxation block
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HOPFIELD_ANNEALING_RELAXATION_DEFINES_SVH
`define HOPFIELD_ANNEALING_RELAXATION_DEFINES_SVH

`ifndef SYNTH
`define HAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define HAR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");
`else
`define HAR_ASSERT(lbl, prop)
`define HAR_ASSERT_NEVER(lbl, expr)
`endif

`endif

/* design/har_pkg.sv */
// ----------------------------------------------------------------------------
// har_pkg
// Shared types, constants and the activation table of the relaxation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package har_pkg;

  localparam int MAX_NEURONS = 64;
  localparam int NIDX_W      = 6;
  localparam int NCNT_W      = 7;
  localparam int Q_W         = 15;
  localparam int TEMP_W      = 16;
  localparam int CADDR_W     = 2 * NIDX_W;
  localparam int TANH_DEPTH  = 256;
  localparam int TIDX_W      = 8;
  localparam int SUM_W       = 21;
  localparam int PROD_W      = 36;
  localparam int PRODQ_W     = 30;
  localparam int DIVR_W      = 31;
  localparam int NET_W       = 37;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [Q_W-1:0]    Q14_ONE     = 15'd16384;
  localparam logic [NCNT_W-1:0] NCNT_MAX    = 7'd64;

  typedef enum logic [1:0] {
    REQ_PAIR   = 2'd0,
    REQ_NEURON = 2'd1,
    REQ_SWEEP  = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_OMEGA  = 3'd0,
    CFG_NCOUNT = 3'd1,
    CFG_TSTART = 3'd2,
    CFG_TFINAL = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_SUM_LAST,
    ST_MULC,
    ST_DIVN,
    ST_WAITN,
    ST_MULQ,
    ST_NET,
    ST_DIVT,
    ST_WAITT,
    ST_ACT,
    ST_UPD,
    ST_FIN,
    ST_EMIT_SW,
    ST_EMIT_RD
  } state_e;

  typedef struct packed {
    logic [Q_W-1:0]    omega;
    logic [NCNT_W-1:0] ncount;
    logic [TEMP_W-1:0] tstart;
    logic [TEMP_W-1:0] tfinal;
    logic [Q_W-1:0]    limit;
  } cfg_t;

  typedef struct packed {
    logic clr_step;
    logic load_pair;
    logic load_neuron;
    logic read_issue;
    logic sweep_init;
    logic sum_step;
    logic mulc;
    logic divn_start;
    logic mulq;
    logic net;
    logic divt_start;
    logic act;
    logic upd;
    logic fin;
    logic res_load;
    logic res_read;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic j_last;
    logic i_last;
    logic div_busy;
    logic div_done;
    logic t_zero;
    logic out_busy;
  } status_t;

  typedef logic [Q_W-1:0] act_tbl_t [TANH_DEPTH];

  function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int bitpos = 63; bitpos >= 0; bitpos--) begin
      rem = {rem[62:0], num[bitpos]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned neg_exp_q30(int unsigned k);
    longint unsigned v;
    longint unsigned term;
    longint unsigned sum;
    v    = (longint'(k) << 28) >> 8;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int unsigned n = 1; n <= 7; n++) begin
      term = udiv_u64((term * v) >> 30, 64'(n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int s = 0; s < 6; s++) begin
      sum = (sum * sum) >> 30;
    end
    return sum;
  endfunction

  function automatic act_tbl_t build_act_table();
    act_tbl_t        tbl;
    longint unsigned den;
    for (int unsigned k = 0; k < TANH_DEPTH; k++) begin
      den    = (64'd1 << 30) + neg_exp_q30(k);
      tbl[k] = Q_W'(udiv_u64((64'd16384 << 30) + (den >> 1), den));
    end
    return tbl;
  endfunction

  localparam act_tbl_t ACT_TABLE = build_act_table();

endpackage

`default_nettype wire

/* design/hopfield_annealing_relaxation.sv */
// ----------------------------------------------------------------------------
// hopfield_annealing_relaxation
// Mean-field annealing relaxation network with a 64-neuron conflict graph.
//
// Channel  Direction  Handshake                      Payload
// in       input      in_valid_i / in_ready_o        req_type, row/col index,
//                                                    incompatible, quality,
//                                                    initial_state
// out      output     out_valid_o / out_ready_i      is_stable, neuron_value,
//                                                    current_temperature
// cfg      input      APB psel/penable/pwrite/pready five registers at 4*i
//
// A sweep makes n pair reads per neuron through the conflict and activity
// RAMs, plus two waits on the shared bit-serial divider per neuron; at zero
// temperature the second wait is skipped. After reset a clearing pass
// zeroes all 4096 entries of the conflict RAM; no transaction is taken
// during it. A stalled output holds the next result back, and no request
// is taken while it waits; loads are still taken while an earlier result
// waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hopfield_annealing_relaxation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  req_type_i,
  input  wire logic [har_pkg::NIDX_W-1:0]  row_index_i,
  input  wire logic [har_pkg::NIDX_W-1:0]  col_index_i,
  input  wire logic                        incompatible_i,
  input  wire logic [har_pkg::Q_W-1:0]     quality_i,
  input  wire logic [har_pkg::Q_W-1:0]     initial_state_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             is_stable_o,
  output logic      [har_pkg::Q_W-1:0]     neuron_value_o,
  output logic      [har_pkg::TEMP_W-1:0]  current_temperature_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [har_pkg::PADDR_W-1:0] paddr,
  input  wire logic [har_pkg::PDATA_W-1:0] pwdata,
  output logic      [har_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import har_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  status_t  status;
  cfg_idx_e cfg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.omega  <= 15'd8192;
      cfg_q.ncount <= NCNT_MAX;
      cfg_q.tstart <= '0;
      cfg_q.tfinal <= '0;
      cfg_q.limit  <= 15'd164;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OMEGA:  cfg_q.omega  <= pwdata[Q_W-1:0];
        CFG_NCOUNT: cfg_q.ncount <= pwdata[NCNT_W-1:0];
        CFG_TSTART: cfg_q.tstart <= pwdata[TEMP_W-1:0];
        CFG_TFINAL: cfg_q.tfinal <= pwdata[TEMP_W-1:0];
        CFG_LIMIT:  cfg_q.limit  <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_OMEGA:  prdata = PDATA_W'(cfg_q.omega);
      CFG_NCOUNT: prdata = PDATA_W'(cfg_q.ncount);
      CFG_TSTART: prdata = PDATA_W'(cfg_q.tstart);
      CFG_TFINAL: prdata = PDATA_W'(cfg_q.tfinal);
      CFG_LIMIT:  prdata = PDATA_W'(cfg_q.limit);
      default:    prdata = '0;
    endcase
  end

  har_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  har_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_i                 (cfg_q),
    .row_index_i           (row_index_i),
    .col_index_i           (col_index_i),
    .incompatible_i        (incompatible_i),
    .quality_i             (quality_i),
    .initial_state_i       (initial_state_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .is_stable_o           (is_stable_o),
    .neuron_value_o        (neuron_value_o),
    .current_temperature_o (current_temperature_o)
  );

endmodule

`default_nettype wire

/* design/har_ram.sv */
// ----------------------------------------------------------------------------
// har_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module har_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/har_div.sv */
// ----------------------------------------------------------------------------
// har_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module har_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [har_pkg::PROD_W-1:0] dividend_i,
  input  wire logic [har_pkg::DIVR_W-1:0] divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic      [har_pkg::PROD_W-1:0] quotient_o
);
  import har_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVR_W:0]   rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DIVR_W-1:0] dvs_q, dvs_d;
  logic [DIVR_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_q[DIVR_W-1:0], quo_q[PROD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_W'(PROD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? shifted - {1'b0, dvs_q} : shifted;
      quo_d = {quo_q[PROD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* design/har_ctrl.sv */
// ----------------------------------------------------------------------------
// har_ctrl
// Sequencer: clearing pass, transaction decode and sweep steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module har_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       req_type_i,
  input  wire har_pkg::status_t status_i,
  output har_pkg::cmd_t         cmd_o
);
  import har_pkg::*;
  `include "hopfield_annealing_relaxation_defines.svh"

  state_e state_q, state_d;
  req_e   req;

  assign req = req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (req)
            REQ_PAIR:   cmd_o.load_pair = 1'b1;
            REQ_NEURON: cmd_o.load_neuron = 1'b1;
            REQ_SWEEP: begin
              cmd_o.sweep_init = 1'b1;
              state_d          = ST_SUM;
            end
            REQ_READ: begin
              cmd_o.read_issue = 1'b1;
              state_d          = ST_EMIT_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (status_i.j_last) state_d = ST_SUM_LAST;
      end
      ST_SUM_LAST: state_d = ST_MULC;
      ST_MULC: begin
        cmd_o.mulc = 1'b1;
        state_d    = ST_DIVN;
      end
      ST_DIVN: begin
        cmd_o.divn_start = 1'b1;
        state_d          = ST_WAITN;
      end
      ST_WAITN: begin
        if (status_i.div_done) state_d = ST_MULQ;
      end
      ST_MULQ: begin
        cmd_o.mulq = 1'b1;
        state_d    = ST_NET;
      end
      ST_NET: begin
        cmd_o.net = 1'b1;
        state_d   = status_i.t_zero ? ST_ACT : ST_DIVT;
      end
      ST_DIVT: begin
        cmd_o.divt_start = 1'b1;
        state_d          = ST_WAITT;
      end
      ST_WAITT: begin
        if (status_i.div_done) state_d = ST_ACT;
      end
      ST_ACT: begin
        cmd_o.act = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = status_i.i_last ? ST_FIN : ST_SUM;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_EMIT_SW;
      end
      ST_EMIT_SW: begin
        if (!status_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (!status_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_read = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  `HAR_ASSERT(a_clear_once, (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
  `HAR_ASSERT_NEVER(a_div_overlap, (cmd_o.divn_start || cmd_o.divt_start) && status_i.div_busy)
  `HAR_ASSERT(a_sum_exit, (state_q == ST_SUM && state_d != ST_SUM) |-> status_i.j_last)
  `HAR_ASSERT(a_div_result, (state_q == ST_WAITT && state_d == ST_ACT) |-> !status_i.t_zero)

endmodule

`default_nettype wire

/* design/har_dp.sv */
// ----------------------------------------------------------------------------
// har_dp
// Datapath: graph and neuron stores, sums, net input, activation, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module har_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire har_pkg::cmd_t              cmd_i,
  output har_pkg::status_t                status_o,
  input  wire har_pkg::cfg_t              cfg_i,
  input  wire logic [har_pkg::NIDX_W-1:0] row_index_i,
  input  wire logic [har_pkg::NIDX_W-1:0] col_index_i,
  input  wire logic                       incompatible_i,
  input  wire logic [har_pkg::Q_W-1:0]    quality_i,
  input  wire logic [har_pkg::Q_W-1:0]    initial_state_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            is_stable_o,
  output logic      [har_pkg::Q_W-1:0]    neuron_value_o,
  output logic      [har_pkg::TEMP_W-1:0] current_temperature_o
);
  import har_pkg::*;

  logic [CADDR_W-1:0] clr_cnt_q;
  logic [NIDX_W-1:0]  i_q, j_q, acc_j_q;
  logic               acc_en_q;
  logic [SUM_W-1:0]   sum_c_q, sum_i_q;
  logic [Q_W-1:0]     old_q, nv_q;
  logic [PROD_W-1:0]  prodc_q;
  logic [PRODQ_W-1:0] prodq_q;
  logic signed [NET_W-1:0] net_q;
  logic [TEMP_W-1:0]  temp_q;
  logic               stable_q;
  logic               out_valid_q;

  logic [NCNT_W-1:0]  n_sat;
  logic [NCNT_W-1:0]  n_last;
  logic [Q_W-1:0]     om;
  logic [Q_W-1:0]     q_sat, s_sat;
  logic               conf_rd;
  logic [Q_W-1:0]     act_rd, qual_rd;
  logic               cram_we, aram_we, aram_re;
  logic [CADDR_W-1:0] cram_waddr;
  logic [NIDX_W-1:0]  aram_waddr, aram_raddr;
  logic [Q_W-1:0]     aram_wdata;
  logic               div_start, div_busy, div_done;
  logic [PROD_W-1:0]  div_dividend, quo;
  logic [DIVR_W-1:0]  div_divisor;
  logic [PROD_W-1:0]  mag;
  logic [Q_W-1:0]     tbl_v, act_v, nv_d, diff;
  logic [TEMP_W:0]    t_sum;

  always_comb begin
    if (cfg_i.ncount == '0) begin
      n_sat = NCNT_W'(1);
    end else if (cfg_i.ncount > NCNT_MAX) begin
      n_sat = NCNT_MAX;
    end else begin
      n_sat = cfg_i.ncount;
    end
  end
  assign n_last = n_sat - 1'b1;
  assign om     = (cfg_i.omega > Q14_ONE) ? Q14_ONE : cfg_i.omega;
  assign q_sat  = (quality_i > Q14_ONE) ? Q14_ONE : quality_i;
  assign s_sat  = (initial_state_i > Q14_ONE) ? Q14_ONE : initial_state_i;

  assign cram_we    = cmd_i.clr_step | cmd_i.load_pair;
  assign cram_waddr = cmd_i.clr_step ? clr_cnt_q : {row_index_i, col_index_i};

  har_ram #(.WIDTH(1), .DEPTH(MAX_NEURONS * MAX_NEURONS)) u_conf_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i (cmd_i.load_pair & incompatible_i),
    .re_i    (cmd_i.sum_step),
    .raddr_i ({i_q, j_q}),
    .rdata_o (conf_rd)
  );

  assign aram_we    = cmd_i.load_neuron | cmd_i.upd;
  assign aram_waddr = cmd_i.load_neuron ? row_index_i : i_q;
  assign aram_wdata = cmd_i.load_neuron ? s_sat : nv_q;
  assign aram_re    = cmd_i.sum_step | cmd_i.read_issue;
  assign aram_raddr = cmd_i.read_issue ? row_index_i : j_q;

  har_ram #(.WIDTH(Q_W), .DEPTH(MAX_NEURONS)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (aram_we),
    .waddr_i (aram_waddr),
    .wdata_i (aram_wdata),
    .re_i    (aram_re),
    .raddr_i (aram_raddr),
    .rdata_o (act_rd)
  );

  har_ram #(.WIDTH(Q_W), .DEPTH(MAX_NEURONS)) u_qual_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_neuron),
    .waddr_i (row_index_i),
    .wdata_i (q_sat),
    .re_i    (1'b1),
    .raddr_i (i_q),
    .rdata_o (qual_rd)
  );

  assign mag          = net_q[NET_W-1] ? PROD_W'(-net_q) : PROD_W'(net_q);
  assign div_start    = cmd_i.divn_start | cmd_i.divt_start;
  assign div_dividend = cmd_i.divn_start ? prodc_q : mag;
  assign div_divisor  = cmd_i.divn_start ? DIVR_W'(n_sat)
                                         : {temp_q, {(DIVR_W - TEMP_W){1'b0}}};

  har_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign tbl_v = ACT_TABLE[quo[TIDX_W-1:0]];
  assign act_v = (|quo[PROD_W-1:TIDX_W]) ? Q14_ONE : tbl_v;
  always_comb begin
    if (temp_q == '0) begin
      nv_d = Q14_ONE;
    end else if (net_q[NET_W-1]) begin
      nv_d = Q14_ONE - act_v;
    end else begin
      nv_d = act_v;
    end
  end
  assign diff  = (old_q > nv_q) ? old_q - nv_q : nv_q - old_q;
  assign t_sum = {1'b0, temp_q} + {1'b0, cfg_i.tfinal};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      acc_en_q    <= 1'b0;
      temp_q      <= '0;
      stable_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.sum_step;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.sweep_init) begin
        i_q      <= '0;
        j_q      <= '0;
        stable_q <= 1'b1;
      end
      if (cmd_i.sum_step) j_q <= j_q + 1'b1;
      if (cmd_i.upd) begin
        i_q <= i_q + 1'b1;
        j_q <= '0;
        if (diff > cfg_i.limit) stable_q <= 1'b0;
      end
      if (cmd_i.load_neuron) temp_q <= cfg_i.tstart;
      if (cmd_i.fin) temp_q <= t_sum[TEMP_W:1];
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_j_q <= j_q;
    if (cmd_i.sweep_init || cmd_i.upd) begin
      sum_c_q <= '0;
      sum_i_q <= '0;
    end else if (acc_en_q) begin
      if (acc_j_q == i_q) begin
        old_q <= act_rd;
      end else if (conf_rd) begin
        sum_i_q <= sum_i_q + SUM_W'(act_rd);
      end else begin
        sum_c_q <= sum_c_q + SUM_W'(act_rd);
      end
    end
    if (cmd_i.mulc) prodc_q <= PROD_W'((Q14_ONE - om) * sum_c_q);
    if (cmd_i.mulq) prodq_q <= om * qual_rd;
    if (cmd_i.net) begin
      net_q <= $signed({{(NET_W - PRODQ_W){1'b0}}, prodq_q})
             + $signed({2'b0, quo[PROD_W-2:0]})
             - $signed({2'b0, sum_i_q, 14'b0});
    end
    if (cmd_i.act) nv_q <= nv_d;
    if (cmd_i.res_load) begin
      is_stable_o           <= cmd_i.res_read ? 1'b0 : stable_q;
      neuron_value_o        <= cmd_i.res_read ? act_rd : '0;
      current_temperature_o <= temp_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.clr_done = &clr_cnt_q;
  assign status_o.j_last   = {1'b0, j_q} == n_last;
  assign status_o.i_last   = {1'b0, i_q} == n_last;
  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;
  assign status_o.t_zero   = temp_q == '0;
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

`default_nettype wire

/* dv/har_checker.sv */
// ----------------------------------------------------------------------------
// har_checker
// Watches the request, result and register channels of the relaxation block,
// keeps its own copy of the graph, neuron stores, temperature and registers,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module har_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   req_type_i,
  input  logic [har_pkg::NIDX_W-1:0]   row_index_i,
  input  logic [har_pkg::NIDX_W-1:0]   col_index_i,
  input  logic                         incompatible_i,
  input  logic [har_pkg::Q_W-1:0]      quality_i,
  input  logic [har_pkg::Q_W-1:0]      initial_state_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         is_stable_i,
  input  logic [har_pkg::Q_W-1:0]      neuron_value_i,
  input  logic [har_pkg::TEMP_W-1:0]   current_temperature_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [har_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [har_pkg::PDATA_W-1:0]  pwdata_i,
  input  logic                         pready_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import har_pkg::*;

  typedef struct {
    logic              stable;
    logic [Q_W-1:0]    value;
    logic [TEMP_W-1:0] temp;
  } har_result_t;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  logic [Q_W-1:0]    sigmoid_lut [TANH_DEPTH];
  bit                conflict_mem [MAX_NEURONS*MAX_NEURONS];
  logic [Q_W-1:0]    quality_mem [MAX_NEURONS];
  logic [Q_W-1:0]    activity_mem [MAX_NEURONS];
  logic [TEMP_W-1:0] temp_q;
  logic [Q_W-1:0]    omega_q;
  logic [NCNT_W-1:0] ncount_q;
  logic [TEMP_W-1:0] tstart_q;
  logic [TEMP_W-1:0] tfinal_q;
  logic [Q_W-1:0]    limit_q;
  har_result_t       result_fifo [$];
  int                fails;

  function automatic longint unsigned decay_q30(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned acc;
    x    = (longint'(k) << 28) / TANH_DEPTH;
    term = ONE_Q30;
    acc  = ONE_Q30;
    for (int unsigned m = 1; m <= 7; m++) begin
      term = ((term * x) >> 30) / m;
      if (m % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    repeat (6) acc = (acc * acc) >> 30;
    return acc;
  endfunction

  function automatic logic [Q_W-1:0] clip_q14(logic [Q_W-1:0] v);
    return (v > 15'd16384) ? 15'd16384 : v;
  endfunction

  function automatic logic [Q_W-1:0] squash(longint net, logic [TEMP_W-1:0] t);
    longint unsigned mag;
    longint unsigned idx;
    logic [Q_W-1:0]  v;
    if (t == 0) return 15'd16384;
    mag = (net < 0) ? longint'(-net) : longint'(net);
    idx = (mag * TANH_DEPTH) / (longint'(t) << 23);
    v   = (idx >= TANH_DEPTH) ? 15'd16384 : sigmoid_lut[idx];
    return (net < 0) ? 15'd16384 - v : v;
  endfunction

  function automatic bit relax_pass();
    int unsigned     n;
    longint unsigned om;
    longint unsigned sum_c;
    longint unsigned sum_i;
    longint unsigned pos;
    longint          net;
    logic [Q_W-1:0]  nv;
    logic [Q_W-1:0]  old;
    bit              stable;
    n      = ncount_q;
    om     = clip_q14(omega_q);
    stable = 1'b1;
    if (n < 1) n = 1;
    if (n > MAX_NEURONS) n = MAX_NEURONS;
    for (int unsigned i = 0; i < n; i++) begin
      sum_c = 0;
      sum_i = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (j != i) begin
          if (conflict_mem[i*MAX_NEURONS+j]) sum_i += activity_mem[j];
          else sum_c += activity_mem[j];
        end
      end
      pos = om * quality_mem[i] + ((64'd16384 - om) * sum_c) / n;
      net = longint'(pos) - longint'(sum_i * 64'd16384);
      nv  = squash(net, temp_q);
      old = activity_mem[i];
      if (((old > nv) ? old - nv : nv - old) > limit_q) stable = 1'b0;
      activity_mem[i] = nv;
    end
    temp_q = TEMP_W'(({1'b0, temp_q} + {1'b0, tfinal_q}) >> 1);
    return stable;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    longint unsigned den;
    fails = 0;
    for (int unsigned k = 0; k < TANH_DEPTH; k++) begin
      den = ONE_Q30 + decay_q30(k);
      sigmoid_lut[k] = Q_W'(((64'd16384 << 30) + den / 2) / den);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    har_result_t got;
    har_result_t want;
    if (!rst_ni) begin
      foreach (conflict_mem[k]) conflict_mem[k] = 1'b0;
      foreach (quality_mem[k]) quality_mem[k] = '0;
      foreach (activity_mem[k]) activity_mem[k] = '0;
      temp_q   = '0;
      omega_q  = 15'd8192;
      ncount_q = 7'd64;
      tstart_q = '0;
      tfinal_q = '0;
      limit_q  = 15'd164;
      result_fifo.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = result_fifo.pop_front();
          if (is_stable_i !== want.stable)
            report_mismatch("is_stable", is_stable_i, want.stable);
          if (neuron_value_i !== want.value)
            report_mismatch("neuron_value", neuron_value_i, want.value);
          if (current_temperature_i !== want.temp)
            report_mismatch("current_temperature", current_temperature_i, want.temp);
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (req_e'(req_type_i))
          REQ_PAIR: conflict_mem[{row_index_i, col_index_i}] = incompatible_i;
          REQ_NEURON: begin
            quality_mem[row_index_i]  = clip_q14(quality_i);
            activity_mem[row_index_i] = clip_q14(initial_state_i);
            temp_q = tstart_q;
          end
          REQ_SWEEP: begin
            got.stable = relax_pass();
            got.value  = '0;
            got.temp   = temp_q;
            result_fifo.push_back(got);
          end
          default: begin
            got.stable = 1'b0;
            got.value  = activity_mem[row_index_i];
            got.temp   = temp_q;
            result_fifo.push_back(got);
          end
        endcase
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_idx_e'(paddr_i[4:2]))
          CFG_OMEGA:  omega_q  = pwdata_i[Q_W-1:0];
          CFG_NCOUNT: ncount_q = pwdata_i[NCNT_W-1:0];
          CFG_TSTART: tstart_q = pwdata_i[TEMP_W-1:0];
          CFG_TFINAL: tfinal_q = pwdata_i[TEMP_W-1:0];
          CFG_LIMIT:  limit_q  = pwdata_i[Q_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o    <= result_fifo.size();
    fail_count_o <= fails;
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the relaxation block with directed and random requests and register
// settings under random idling on both channels; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import har_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          req_type = '0;
  logic [NIDX_W-1:0]   row_index = '0;
  logic [NIDX_W-1:0]   col_index = '0;
  logic                incompatible = 1'b0;
  logic [Q_W-1:0]      quality = '0;
  logic [Q_W-1:0]      initial_state = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                is_stable;
  logic [Q_W-1:0]      neuron_value;
  logic [TEMP_W-1:0]   current_temperature;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  bit                  idling = 1'b1;
  int                  quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hopfield_annealing_relaxation dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .row_index_i(row_index), .col_index_i(col_index),
    .incompatible_i(incompatible), .quality_i(quality),
    .initial_state_i(initial_state),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .is_stable_o(is_stable), .neuron_value_o(neuron_value),
    .current_temperature_o(current_temperature),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  har_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .row_index_i(row_index), .col_index_i(col_index),
    .incompatible_i(incompatible), .quality_i(quality),
    .initial_state_i(initial_state),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .is_stable_i(is_stable), .neuron_value_i(neuron_value),
    .current_temperature_i(current_temperature),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    out_ready <= idling ? ($urandom_range(99) >= 29) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_req(req_e kind, int row, int col, bit inc, int q, int s);
    if (idling && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_type      <= kind;
    row_index     <= NIDX_W'(row);
    col_index     <= NIDX_W'(col);
    incompatible  <= inc;
    quality       <= Q_W'(q);
    initial_state <= Q_W'(s);
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_req();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      send_req(REQ_PAIR, $urandom_range(63), $urandom_range(63), $urandom_range(1), 0, 0);
    end else if (r < 50) begin
      send_req(REQ_NEURON, $urandom_range(63), 0, 0, $urandom_range(32767),
               $urandom_range(32767));
    end else if (r < 62) begin
      send_req(REQ_SWEEP, $urandom_range(63), $urandom_range(63), $urandom_range(1),
               $urandom_range(32767), $urandom_range(32767));
    end else begin
      send_req(REQ_READ, $urandom_range(63), $urandom_range(63), $urandom_range(1),
               $urandom_range(32767), $urandom_range(32767));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_OMEGA, 8192);
    write_reg(CFG_NCOUNT, 4);
    write_reg(CFG_TSTART, 256);
    write_reg(CFG_TFINAL, 64);
    write_reg(CFG_LIMIT, 164);

    send_req(REQ_PAIR, 0, 1, 1, 0, 0);
    send_req(REQ_PAIR, 1, 0, 1, 0, 0);
    send_req(REQ_PAIR, 63, 63, 1, 0, 0);
    send_req(REQ_PAIR, 2, 3, 0, 0, 0);
    send_req(REQ_PAIR, 0, 0, 1, 0, 0);
    send_req(REQ_NEURON, 0, 0, 0, 0, 0);
    send_req(REQ_NEURON, 1, 0, 0, 16384, 16384);
    send_req(REQ_NEURON, 2, 0, 0, 32767, 32767);
    send_req(REQ_NEURON, 3, 0, 0, $urandom_range(16384), $urandom_range(16384));
    for (int i = 0; i < 4; i++) send_req(REQ_READ, i, 0, 0, 0, 0);
    repeat (3) send_req(REQ_SWEEP, 0, 0, 0, 0, 0);
    send_req(REQ_READ, 2, 0, 0, 0, 0);
    drain_results();

    // zero temperature
    write_reg(CFG_TSTART, 0);
    write_reg(CFG_OMEGA, 0);
    send_req(REQ_NEURON, 3, 0, 0, 100, 200);
    send_req(REQ_SWEEP, 0, 0, 0, 0, 0);
    send_req(REQ_READ, 3, 0, 0, 0, 0);
    drain_results();
    write_reg(CFG_NCOUNT, 0);
    write_reg(CFG_OMEGA, 32767);
    send_req(REQ_SWEEP, 0, 0, 0, 0, 0);
    drain_results();

    write_reg(CFG_TSTART, $urandom_range(65535));
    for (int i = 0; i < 64; i++)
      send_req(REQ_NEURON, i, 0, 0, $urandom_range(32767), $urandom_range(32767));

    for (int p = 0; p < 4; p++) begin
      drain_results();
      idling = (p != 2);
      case (p)
        0: begin
          write_reg(CFG_OMEGA, 0);
          write_reg(CFG_NCOUNT, 127);
          write_reg(CFG_TSTART, 65535);
          write_reg(CFG_TFINAL, 0);
          write_reg(CFG_LIMIT, 0);
        end
        2: begin
          write_reg(CFG_OMEGA, 32767);
          write_reg(CFG_NCOUNT, 64);
          write_reg(CFG_TSTART, 1);
          write_reg(CFG_TFINAL, 65535);
          write_reg(CFG_LIMIT, 32767);
        end
        default: begin
          write_reg(CFG_OMEGA, $urandom_range(16384));
          write_reg(CFG_NCOUNT, $urandom_range(64, 1));
          write_reg(CFG_TSTART, $urandom_range(4095));
          write_reg(CFG_TFINAL, $urandom_range(1023));
          write_reg(CFG_LIMIT, $urandom_range(2000));
        end
      endcase
      for (int k = 0; k < 14; k++) begin
        if (k == 7) drain_results();
        random_req();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* hopfield_annealing_relaxation.f */
+incdir+design
design/har_pkg.sv
design/har_ram.sv
design/har_div.sv
design/har_ctrl.sv
design/har_dp.sv
design/hopfield_annealing_relaxation.sv
dv/har_checker.sv
dv/testbench.sv
